### src/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg: shared definitions for the MIPS integer subset core
// Opcode and function codes, register numbers and default sizes.
// ----------------------------------------------------------------------------
package msc_pkg;

    // Default sizes handed to the core parameters.
    localparam int DEF_MEM_ADDR_BITS = 16;
    localparam int DEF_PC_BITS       = 16;

    // Field widths of the instruction encoding.
    localparam int WORD_BITS = 32;
    localparam int REG_BITS  = 5;
    localparam int REG_COUNT = 32;

    typedef logic [5:0]          t_opcode;
    typedef logic [5:0]          t_funct;
    typedef logic [REG_BITS-1:0] t_reg_idx;
    typedef logic [WORD_BITS-1:0] t_word;

    // Primary opcodes.
    localparam t_opcode OP_RTYPE = 6'b000000;
    localparam t_opcode OP_J     = 6'b000010;
    localparam t_opcode OP_JAL   = 6'b000011;
    localparam t_opcode OP_BEQ   = 6'b000100;
    localparam t_opcode OP_BNE   = 6'b000101;
    localparam t_opcode OP_BLEZ  = 6'b000110;
    localparam t_opcode OP_BGTZ  = 6'b000111;
    localparam t_opcode OP_LW    = 6'b100011;
    localparam t_opcode OP_SW    = 6'b101011;

    // R-format function codes.
    localparam t_funct FN_SLL = 6'b000000;
    localparam t_funct FN_SRL = 6'b000010;
    localparam t_funct FN_JR  = 6'b001000;
    localparam t_funct FN_ADD = 6'b100000;
    localparam t_funct FN_SUB = 6'b100010;

    // Register numbers with a fixed role.
    localparam t_reg_idx REG_ZERO = 5'd0;
    localparam t_reg_idx REG_LINK = 5'd31;

endpackage

### src/mips_subset_core.sv
// ----------------------------------------------------------------------------
// mips_subset_core: single-issue MIPS32 integer subset core
// Executes one instruction per transfer and reports its effects.
// ----------------------------------------------------------------------------
// Path: the execute stage, then the result register; lw also waits on the registered read.
// Throughput: one instruction per cycle while results are taken; lw is slower because the data
// memory read is registered and the execute stage holds the load for it.
// Reset: PC and register file valid bits clear at once; the data memory is then
// swept to zero, one word a cycle, over all 2**MEM_ADDR_BITS words, with ready low.
// ----------------------------------------------------------------------------
module mips_subset_core
    import msc_pkg::*;
#(
    parameter int MEM_ADDR_BITS = DEF_MEM_ADDR_BITS,
    parameter int PC_BITS       = DEF_PC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Instruction channel.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [31:0]        i_instr_word,
    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_exec_pc,
    output logic [15:0]        o_next_pc,
    output logic               o_transfer_taken,
    output logic               o_reg_written,
    output logic [4:0]         o_dest_reg,
    output logic signed [31:0] o_write_value,
    output logic               o_mem_written,
    output logic [15:0]        o_mem_addr,
    output logic signed [31:0] o_store_value
);

    localparam int MEM_DEPTH = 2 ** MEM_ADDR_BITS;

    // Storage.
    t_word                    rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0]     r_rf_vld;
    t_word                    data_mem [MEM_DEPTH];

    // Clearing sweep of the data memory.
    logic                     r_clr_active;
    logic [MEM_ADDR_BITS-1:0] r_clr_addr;

    // Execute stage.
    logic                     r_s1_valid;
    logic                     r_s1_load_wait;
    t_word                    r_s1_instr;
    logic [PC_BITS-1:0]       r_pc;
    t_word                    r_a_ram;
    t_word                    r_b_ram;
    logic                     r_a_vld;
    logic                     r_b_vld;
    logic                     r_fwd_a;
    logic                     r_fwd_b;
    t_word                    r_fwd_val;
    t_word                    r_mem_rdata;

    // Result register.
    logic                     r_out_valid;
    logic [15:0]              r_exec_pc;
    logic [15:0]              r_next_pc;
    logic                     r_taken;
    logic                     r_reg_we;
    t_reg_idx                 r_dest;
    t_word                    r_wval;
    logic                     r_mem_we;
    logic [15:0]              r_maddr;
    t_word                    r_sval;

    // Decoded fields and execute results.
    t_opcode                  op;
    t_funct                   fn;
    t_reg_idx                 rs_in;
    t_reg_idx                 rt_in;
    t_reg_idx                 rd;
    t_reg_idx                 rt;
    logic [4:0]               shamt;
    t_word                    imm_sx;
    t_word                    opa;
    t_word                    opb;
    t_word                    ea;
    logic [PC_BITS-1:0]       seq_pc;
    logic [PC_BITS-1:0]       c_next;
    logic                     c_taken;
    logic                     c_we;
    t_reg_idx                 c_dest;
    t_word                    c_wval;
    logic                     c_memwe;
    logic                     c_is_mem;
    logic                     c_is_load;
    logic [MEM_ADDR_BITS-1:0] c_maddr;
    t_word                    c_sval;
    t_word                    pc_ext;
    t_word                    next_ext;
    t_word                    maddr_ext;
    logic                     s1_done;
    logic                     s1_adv;
    logic                     in_xfer;

    // Handshake and stage advance.
    assign s1_done    = !c_is_load || r_s1_load_wait;
    assign s1_adv     = r_s1_valid && s1_done && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clr_active && (!r_s1_valid || s1_adv);
    assign in_xfer    = i_in_valid && o_in_ready;

    // Instruction fields.
    assign rs_in  = i_instr_word[25:21];
    assign rt_in  = i_instr_word[20:16];
    assign op     = r_s1_instr[31:26];
    assign rt     = r_s1_instr[20:16];
    assign rd     = r_s1_instr[15:11];
    assign shamt  = r_s1_instr[10:6];
    assign fn     = r_s1_instr[5:0];
    assign imm_sx = {{16{r_s1_instr[15]}}, r_s1_instr[15:0]};

    // Operands: forwarded result, register file word, or zero if never written.
    always_comb begin
        opa = r_a_vld ? r_a_ram : '0;
        opb = r_b_vld ? r_b_ram : '0;
        if (r_fwd_a) begin
            opa = r_fwd_val;
        end
        if (r_fwd_b) begin
            opb = r_fwd_val;
        end
    end

    assign ea      = opa + imm_sx;
    assign seq_pc  = r_pc + PC_BITS'(1);

    // Instruction decode and execute.
    always_comb begin
        c_next    = seq_pc;
        c_taken   = 1'b0;
        c_we      = 1'b0;
        c_dest    = rd;
        c_wval    = '0;
        c_memwe   = 1'b0;
        c_is_mem  = 1'b0;
        c_is_load = 1'b0;
        c_maddr   = ea[MEM_ADDR_BITS-1:0];
        c_sval    = '0;
        unique case (op)
            OP_RTYPE: begin
                c_we = 1'b1;
                case (fn)
                    FN_JR: begin
                        c_we    = 1'b0;
                        c_next  = opa[PC_BITS-1:0];
                        c_taken = 1'b1;
                    end
                    FN_SUB:  c_wval = opa - opb;
                    FN_SLL:  c_wval = opb << shamt;
                    FN_SRL:  c_wval = opb >> shamt;
                    default: c_wval = opa + opb;
                endcase
            end
            OP_LW: begin
                c_is_mem  = 1'b1;
                c_is_load = 1'b1;
                c_we      = 1'b1;
                c_dest    = rt;
                c_wval    = r_mem_rdata;
            end
            OP_SW: begin
                c_is_mem = 1'b1;
                c_memwe  = 1'b1;
                c_sval   = opb;
            end
            OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
                case (op)
                    OP_BEQ:  c_taken = (opa == opb);
                    OP_BNE:  c_taken = (opa != opb);
                    OP_BLEZ: c_taken = opa[31] || (opa == '0);
                    default: c_taken = !opa[31] && (opa != '0);
                endcase
                if (c_taken) begin
                    c_next = PC_BITS'(seq_pc + imm_sx[PC_BITS-1:0]);
                end
            end
            OP_J, OP_JAL: begin
                c_next  = r_s1_instr[PC_BITS-1:0];
                c_taken = 1'b1;
                if (op == OP_JAL) begin
                    c_we   = 1'b1;
                    c_dest = REG_LINK;
                    c_wval = 32'(seq_pc);
                end
            end
            default: begin
            end
        endcase
        // Writes to r0 are dropped.
        if (!c_we || c_dest == REG_ZERO) begin
            c_we   = 1'b0;
            c_dest = REG_ZERO;
            c_wval = '0;
        end
        if (!c_is_mem) begin
            c_maddr = '0;
        end
    end

    // Width adaptation to the 16-bit result fields.
    assign pc_ext    = 32'(r_pc);
    assign next_ext  = 32'(c_next);
    assign maddr_ext = 32'(c_maddr);

    // Register file: read at transfer, write when the instruction retires.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_ram <= rf_mem[rs_in];
            r_b_ram <= rf_mem[rt_in];
        end
        if (s1_adv && c_we) begin
            rf_mem[c_dest] <= c_wval;
        end
    end

    // Register valid bits: an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (s1_adv && c_we) begin
            r_rf_vld[c_dest] <= 1'b1;
        end
    end

    // Operand capture, with a bypass from the instruction retiring at the same edge.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_instr <= i_instr_word;
            r_a_vld    <= r_rf_vld[rs_in];
            r_b_vld    <= r_rf_vld[rt_in];
            r_fwd_a    <= s1_adv && c_we && (c_dest == rs_in);
            r_fwd_b    <= s1_adv && c_we && (c_dest == rt_in);
            r_fwd_val  <= c_wval;
        end
    end

    // Data memory: one write port shared by the clearing sweep and stores.
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            data_mem[r_clr_addr] <= '0;
        end else if (s1_adv && c_memwe) begin
            data_mem[c_maddr] <= c_sval;
        end
    end

    // Data memory read for the first cycle of a load.
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && c_is_load && !r_s1_load_wait) begin
            r_mem_rdata <= data_mem[c_maddr];
        end
    end

    // Clearing sweep after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + MEM_ADDR_BITS'(1);
            if (&r_clr_addr) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // Execute stage control and program counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_s1_load_wait <= 1'b0;
            r_pc           <= '0;
        end else begin
            if (s1_adv) begin
                r_pc           <= c_next;
                r_s1_load_wait <= 1'b0;
            end else if (r_s1_valid && c_is_load) begin
                r_s1_load_wait <= 1'b1;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_exec_pc <= pc_ext[15:0];
            r_next_pc <= next_ext[15:0];
            r_taken   <= c_taken;
            r_reg_we  <= c_we;
            r_dest    <= c_dest;
            r_wval    <= c_wval;
            r_mem_we  <= c_memwe;
            r_maddr   <= maddr_ext[15:0];
            r_sval    <= c_sval;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_exec_pc        = r_exec_pc;
    assign o_next_pc        = r_next_pc;
    assign o_transfer_taken = r_taken;
    assign o_reg_written    = r_reg_we;
    assign o_dest_reg       = r_dest;
    assign o_write_value    = r_wval;
    assign o_mem_written    = r_mem_we;
    assign o_mem_addr       = r_maddr;
    assign o_store_value    = r_sval;

    // No instruction is taken while the data memory is being cleared.
    a_no_xfer_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !o_in_ready)
        else $error("instruction transfer during memory clear");

    // Register zero is never reported as written.
    a_no_r0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_reg_written && (o_dest_reg == REG_ZERO)))
        else $error("write to r0 reported");

    // A store never also writes a register.
    a_store_no_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_mem_written && o_reg_written))
        else $error("store reported a register write");

    // A load retires only after its data memory read cycle.
    a_load_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && c_is_load) |-> r_s1_load_wait)
        else $error("load retired without memory read");

endmodule
